@@ hw/rtl/pme_pkg.sv @@
// ----------------------------------------------------------------------------
// pme_pkg
// shared types, opcodes and constants of the pascal stack machine executor
// ----------------------------------------------------------------------------
`default_nettype none

package pme_pkg;

    localparam int WORD_BITS      = 32;
    localparam int PC_BITS        = 10;
    localparam int STACK_DEPTH    = 4096;
    localparam int DISPLAY_LEVELS = 16;
    localparam int OPC_BITS       = 6;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 3;

    typedef logic [OPC_BITS-1:0]  opc_t;
    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [PC_BITS-1:0]   pc_t;
    typedef logic [1:0]           status_t;
    typedef logic [3:0]           alu_op_t;

    localparam status_t ST_RUN   = 2'd0;
    localparam status_t ST_HALT  = 2'd1;
    localparam status_t ST_DIVZ  = 2'd2;
    localparam status_t ST_FAULT = 2'd3;

    localparam opc_t OP_INIT    = 6'd0;
    localparam opc_t OP_ADD     = 6'd1;
    localparam opc_t OP_SUB     = 6'd2;
    localparam opc_t OP_MUL     = 6'd3;
    localparam opc_t OP_DIV     = 6'd4;
    localparam opc_t OP_NEG     = 6'd5;
    localparam opc_t OP_AND     = 6'd6;
    localparam opc_t OP_OR      = 6'd7;
    localparam opc_t OP_NOT     = 6'd8;
    localparam opc_t OP_LT      = 6'd9;
    localparam opc_t OP_GT      = 6'd10;
    localparam opc_t OP_EQ      = 6'd11;
    localparam opc_t OP_LE      = 6'd12;
    localparam opc_t OP_GE      = 6'd13;
    localparam opc_t OP_NE      = 6'd14;
    localparam opc_t OP_NOP     = 6'd15;
    localparam opc_t OP_READ    = 6'd16;
    localparam opc_t OP_PRINT   = 6'd17;
    localparam opc_t OP_PUSHC   = 6'd18;
    localparam opc_t OP_ALLOC   = 6'd19;
    localparam opc_t OP_DEALLOC = 6'd20;
    localparam opc_t OP_LOAD    = 6'd21;
    localparam opc_t OP_STORE   = 6'd22;
    localparam opc_t OP_LOADI   = 6'd23;
    localparam opc_t OP_STOREI  = 6'd24;
    localparam opc_t OP_PUSHA   = 6'd25;
    localparam opc_t OP_JUMP    = 6'd26;
    localparam opc_t OP_JMPF    = 6'd27;
    localparam opc_t OP_CALL    = 6'd28;
    localparam opc_t OP_ENTER   = 6'd29;
    localparam opc_t OP_RET     = 6'd30;
    localparam opc_t OP_LABEL   = 6'd31;
    localparam opc_t OP_GOTO    = 6'd32;
    localparam opc_t OP_HALT    = 6'd33;

    localparam alu_op_t ALU_ADD  = 4'd0;
    localparam alu_op_t ALU_SUB  = 4'd1;
    localparam alu_op_t ALU_MUL  = 4'd2;
    localparam alu_op_t ALU_LAND = 4'd3;
    localparam alu_op_t ALU_LOR  = 4'd4;
    localparam alu_op_t ALU_LT   = 4'd5;
    localparam alu_op_t ALU_GT   = 4'd6;
    localparam alu_op_t ALU_EQ   = 4'd7;
    localparam alu_op_t ALU_LE   = 4'd8;
    localparam alu_op_t ALU_GE   = 4'd9;
    localparam alu_op_t ALU_NE   = 4'd10;

endpackage

`default_nettype wire

@@ hw/rtl/pme_alu.sv @@
// ----------------------------------------------------------------------------
// pme_alu
// shared word unit: add, subtract, multiply, logic and signed compares
// ----------------------------------------------------------------------------
`default_nettype none

module pme_alu (
    input  wire pme_pkg::alu_op_t op,
    input  wire pme_pkg::word_t   x,
    input  wire pme_pkg::word_t   y,
    output pme_pkg::word_t        res
);
    import pme_pkg::*;

    logic lt;
    logic eq;

    assign lt = $signed(x) < $signed(y);
    assign eq = x == y;

    always_comb begin
        unique case (op)
            ALU_ADD:  res = x + y;
            ALU_SUB:  res = x - y;
            ALU_MUL:  res = x * y;
            ALU_LAND: res = WORD_BITS'((x != '0) && (y != '0));
            ALU_LOR:  res = WORD_BITS'((x != '0) || (y != '0));
            ALU_LT:   res = WORD_BITS'(lt);
            ALU_GT:   res = WORD_BITS'(!lt && !eq);
            ALU_EQ:   res = WORD_BITS'(eq);
            ALU_LE:   res = WORD_BITS'(lt || eq);
            ALU_GE:   res = WORD_BITS'(!lt);
            ALU_NE:   res = WORD_BITS'(!eq);
            default:  res = x + y;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/pme_div.sv @@
// ----------------------------------------------------------------------------
// pme_div
// signed divider, one quotient bit per cycle, truncating toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module pme_div (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 start,
    input  wire pme_pkg::word_t dividend,
    input  wire pme_pkg::word_t divisor,
    output logic                done,
    output pme_pkg::word_t      quotient
);
    import pme_pkg::*;

    localparam int NW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS:0]   rem_sh;
    logic [WORD_BITS:0]   diff;
    word_t                q_reg;
    word_t                dvs_reg;
    logic                 neg_reg;
    logic [NW-1:0]        n_reg;
    logic                 busy_reg;
    logic                 done_reg;

    assign rem_sh = {rem_reg, q_reg[WORD_BITS-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && n_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            q_reg   <= dividend[WORD_BITS-1] ? (-dividend) : dividend;
            dvs_reg <= divisor[WORD_BITS-1] ? (-divisor) : divisor;
            neg_reg <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
            n_reg   <= NW'(WORD_BITS - 1);
        end else if (busy_reg) begin
            if (!diff[WORD_BITS]) begin
                rem_reg <= diff[WORD_BITS-1:0];
                q_reg   <= {q_reg[WORD_BITS-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[WORD_BITS-1:0];
                q_reg   <= {q_reg[WORD_BITS-2:0], 1'b0};
            end
            n_reg <= n_reg - NW'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (-q_reg) : q_reg;

endmodule

`default_nettype wire

@@ hw/rtl/pascal_stack_machine_executor_unit.sv @@
// ----------------------------------------------------------------------------
// pascal_stack_machine_executor_unit
// executes one stack machine instruction per input beat
// ----------------------------------------------------------------------------
// channel  dir  fields (lsb first)
// s_       in   tdata: opcode, operand_a, operand_b, branch_target, read_value
// m_       out  tdata: next_pc, print_value   tuser: print_valid, status
//
// after reset a clearing pass writes zero to every stack cell, with s_tready low
// an instruction steps through the sequencer states and the stack ram port;
// a division waits on the divider, an unwinding goto loops once per level
// one instruction in flight; a held result stalls only the next instruction
// ----------------------------------------------------------------------------
`default_nettype none

module pascal_stack_machine_executor_unit #(
    parameter int STACK_DEPTH    = pme_pkg::STACK_DEPTH,
    parameter int DISPLAY_LEVELS = pme_pkg::DISPLAY_LEVELS
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // opcode, operand_a, operand_b, branch_target, read_value
    input  wire [pme_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // next_pc, print_value, zero pad
    output logic [pme_pkg::OUT_DATA_W-1:0]    m_tdata,
    // print_valid, status
    output logic [pme_pkg::OUT_USER_W-1:0]    m_tuser
);
    import pme_pkg::*;

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int CW  = AW + 1;
    localparam int LW  = $clog2(DISPLAY_LEVELS);
    localparam int UCW = $clog2(DISPLAY_LEVELS + 1);
    localparam int NW  = WORD_BITS + 2;
    localparam word_t DEPTH_W = WORD_BITS'(STACK_DEPTH);
    localparam word_t LVL_W   = WORD_BITS'(DISPLAY_LEVELS);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_RX    = 4'd3;
    localparam logic [3:0] S_RY    = 4'd4;
    localparam logic [3:0] S_ADR   = 4'd5;
    localparam logic [3:0] S_IND   = 4'd6;
    localparam logic [3:0] S_IND2  = 4'd7;
    localparam logic [3:0] S_EXE   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_WR2   = 4'd10;
    localparam logic [3:0] S_UW    = 4'd11;
    localparam logic [3:0] S_UW1   = 4'd12;
    localparam logic [3:0] S_UW2   = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0]     state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    pc_t            pc_reg, pc_next;
    logic           stop_reg, stop_next;
    logic [AW-1:0]  clr_reg, clr_next;
    word_t          x_reg, x_next;
    word_t          y_reg, y_next;
    word_t          acc_reg, acc_next;
    word_t          cur_reg, cur_next;
    logic [UCW-1:0] ucnt_reg, ucnt_next;

    opc_t           op_reg;
    word_t          a_reg;
    word_t          b_reg;
    pc_t            tgt_reg;
    word_t          rv_reg;

    pc_t            res_pc_reg, res_pc_next;
    logic           res_pv_reg, res_pv_next;
    word_t          res_pval_reg, res_pval_next;
    status_t        res_st_reg, res_st_next;

    logic           m_tvalid_reg;
    pc_t            m_pc_reg;
    logic           m_pv_reg;
    word_t          m_pval_reg;
    status_t        m_st_reg;

    word_t          disp_reg [DISPLAY_LEVELS];
    word_t          sh_reg   [DISPLAY_LEVELS];
    logic [DISPLAY_LEVELS-1:0] dirty_reg;
    logic           disp_we;
    logic [LW-1:0]  disp_wi;
    word_t          disp_wd;
    logic           commit;
    logic           sh_we;
    logic           dirty_clr;

    word_t          mem [STACK_DEPTH];
    word_t          mem_q;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    word_t          mem_wd;
    logic [AW-1:0]  mem_ra;

    alu_op_t        alu_op;
    word_t          alu_x;
    word_t          alu_y;
    word_t          alu_res;

    logic           div_start;
    logic           div_done;
    word_t          div_q;

    logic           accept;
    logic           out_free;
    logic [LW-1:0]  a_idx;
    logic [LW-1:0]  cur_idx;
    word_t          disp_a;
    word_t          dl_val;
    logic           a_ok;
    logic [CW-1:0]  cnt_m1;
    logic [CW-1:0]  cnt_m2;
    logic [CW-1:0]  cnt_m3;
    logic [CW-1:0]  cnt_p1;
    pc_t            pc_inc;
    logic [NW-1:0]  a_sx;
    logic [NW-1:0]  b_sx;
    logic [NW-1:0]  cnt_x;
    logic [NW-1:0]  nc_alloc;
    logic [NW-1:0]  nc_ret;
    logic [NW-1:0]  nc_lbl;

    logic           fin;
    status_t        fin_st;
    pc_t            fin_pc;
    logic           fin_pv;
    word_t          fin_pval;

    pme_alu u_alu (
        .op  (alu_op),
        .x   (alu_x),
        .y   (alu_y),
        .res (alu_res)
    );

    pme_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (x_reg),
        .divisor  (y_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign accept   = s_tvalid && s_tready;
    assign s_tready = state_reg == S_IDLE;
    assign out_free = !m_tvalid_reg || m_tready;

    assign a_idx   = a_reg[LW-1:0];
    assign cur_idx = cur_reg[LW-1:0];
    assign disp_a  = disp_reg[a_idx];
    assign dl_val  = dirty_reg[cur_idx] ? sh_reg[cur_idx] : disp_reg[cur_idx];
    assign a_ok    = a_reg < LVL_W;
    assign cnt_m1  = cnt_reg - CW'(1);
    assign cnt_m2  = cnt_reg - CW'(2);
    assign cnt_m3  = cnt_reg - CW'(3);
    assign cnt_p1  = cnt_reg + CW'(1);
    assign pc_inc  = pc_reg + PC_BITS'(1);
    assign a_sx    = {{2{a_reg[WORD_BITS-1]}}, a_reg};
    assign b_sx    = {{2{b_reg[WORD_BITS-1]}}, b_reg};
    assign cnt_x   = NW'(cnt_reg);
    assign nc_alloc = (op_reg == OP_ALLOC) ? (cnt_x + a_sx) : (cnt_x - a_sx);
    assign nc_ret   = cnt_x - b_sx - NW'(3);
    assign nc_lbl   = {{2{alu_res[WORD_BITS-1]}}, alu_res} + NW'(1);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pc_next       = pc_reg;
        stop_next     = stop_reg;
        clr_next      = clr_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        acc_next      = acc_reg;
        cur_next      = cur_reg;
        ucnt_next     = ucnt_reg;
        res_pc_next   = res_pc_reg;
        res_pv_next   = res_pv_reg;
        res_pval_next = res_pval_reg;
        res_st_next   = res_st_reg;
        disp_we       = 1'b0;
        disp_wi       = a_idx;
        disp_wd       = '0;
        commit        = 1'b0;
        sh_we         = 1'b0;
        dirty_clr     = 1'b0;
        mem_we        = 1'b0;
        mem_wa        = cnt_reg[AW-1:0];
        mem_wd        = '0;
        mem_ra        = cnt_m1[AW-1:0];
        alu_op        = ALU_ADD;
        alu_x         = disp_a;
        alu_y         = b_reg;
        div_start     = 1'b0;
        fin           = 1'b0;
        fin_st        = ST_RUN;
        fin_pc        = pc_inc;
        fin_pv        = 1'b0;
        fin_pval      = '0;

        unique case (state_reg)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(STACK_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                acc_next = alu_res;
                if (stop_reg) begin
                    fin    = 1'b1;
                    fin_st = ST_HALT;
                    fin_pc = pc_reg;
                end else begin
                    unique case (op_reg) inside
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR,
                        OP_LT, OP_GT, OP_EQ, OP_LE, OP_GE, OP_NE: begin
                            if (cnt_reg < CW'(2)) begin
                                fin    = 1'b1;
                                fin_st = ST_FAULT;
                            end else begin
                                mem_ra     = cnt_m2[AW-1:0];
                                state_next = S_RX;
                            end
                        end
                        OP_NEG, OP_NOT, OP_PRINT, OP_JMPF: begin
                            if (cnt_reg == '0) begin
                                fin    = 1'b1;
                                fin_st = ST_FAULT;
                            end else begin
                                state_next = S_RY;
                            end
                        end
                        OP_READ, OP_PUSHC: begin
                            fin = 1'b1;
                            if (cnt_reg >= CW'(STACK_DEPTH)) begin
                                fin_st = ST_FAULT;
                            end else begin
                                mem_we   = 1'b1;
                                mem_wd   = (op_reg == OP_READ) ? rv_reg : a_reg;
                                cnt_next = cnt_p1;
                            end
                        end
                        OP_ALLOC, OP_DEALLOC: begin
                            fin = 1'b1;
                            if (nc_alloc[NW-1] || nc_alloc > NW'(STACK_DEPTH)) begin
                                fin_st = ST_FAULT;
                            end else begin
                                cnt_next = nc_alloc[CW-1:0];
                            end
                        end
                        OP_LOAD, OP_LOADI, OP_PUSHA: begin
                            if (!a_ok || cnt_reg >= CW'(STACK_DEPTH)) begin
                                fin    = 1'b1;
                                fin_st = ST_FAULT;
                            end else begin
                                state_next = S_ADR;
                            end
                        end
                        OP_STORE, OP_STOREI: begin
                            if (!a_ok || cnt_reg == '0) begin
                                fin    = 1'b1;
                                fin_st = ST_FAULT;
                            end else begin
                                state_next = S_ADR;
                            end
                        end
                        OP_LABEL: begin
                            if (!a_ok) begin
                                fin    = 1'b1;
                                fin_st = ST_FAULT;
                            end else begin
                                state_next = S_ADR;
                            end
                        end
                        OP_JUMP: begin
                            fin    = 1'b1;
                            fin_pc = tgt_reg;
                        end
                        OP_CALL: begin
                            if (cnt_p1 >= CW'(STACK_DEPTH)) begin
                                fin    = 1'b1;
                                fin_st = ST_FAULT;
                            end else begin
                                mem_we     = 1'b1;
                                mem_wd     = WORD_BITS'(pc_reg) + WORD_BITS'(1);
                                state_next = S_WR2;
                            end
                        end
                        OP_ENTER: begin
                            fin = 1'b1;
                            if (!a_ok || cnt_reg >= CW'(STACK_DEPTH)) begin
                                fin_st = ST_FAULT;
                            end else begin
                                mem_we   = 1'b1;
                                mem_wd   = disp_a;
                                disp_we  = 1'b1;
                                disp_wd  = WORD_BITS'(cnt_p1);
                                cnt_next = cnt_p1;
                            end
                        end
                        OP_RET: begin
                            if (!a_ok || cnt_reg < CW'(3) || nc_ret[NW-1] ||
                                nc_ret > NW'(STACK_DEPTH)) begin
                                fin    = 1'b1;
                                fin_st = ST_FAULT;
                            end else begin
                                state_next = S_RY;
                            end
                        end
                        OP_GOTO: begin
                            cur_next   = b_reg;
                            ucnt_next  = '0;
                            dirty_clr  = 1'b1;
                            state_next = S_UW;
                        end
                        OP_HALT: begin
                            fin    = 1'b1;
                            fin_st = ST_HALT;
                            fin_pc = pc_reg;
                        end
                        OP_INIT: begin
                            fin      = 1'b1;
                            cnt_next = '0;
                            disp_we  = 1'b1;
                            disp_wi  = '0;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_RX: begin
                x_next     = mem_q;
                state_next = S_RY;
            end
            S_RY: begin
                y_next     = mem_q;
                mem_ra     = cnt_m3[AW-1:0];
                state_next = S_EXE;
            end
            S_ADR: begin
                mem_ra = acc_reg[AW-1:0];
                unique case (op_reg) inside
                    OP_PUSHA: begin
                        fin      = 1'b1;
                        mem_we   = 1'b1;
                        mem_wd   = acc_reg;
                        cnt_next = cnt_p1;
                    end
                    OP_LABEL: begin
                        alu_op = ALU_SUB;
                        alu_x  = acc_reg;
                        alu_y  = WORD_BITS'(1);
                        fin    = 1'b1;
                        if (nc_lbl[NW-1] || nc_lbl > NW'(STACK_DEPTH)) begin
                            fin_st = ST_FAULT;
                        end else begin
                            cnt_next = nc_lbl[CW-1:0];
                        end
                    end
                    default: begin
                        if (acc_reg >= DEPTH_W) begin
                            fin    = 1'b1;
                            fin_st = ST_FAULT;
                        end else if (op_reg == OP_STORE) begin
                            mem_ra     = cnt_m1[AW-1:0];
                            state_next = S_RY;
                        end else begin
                            state_next = S_IND;
                        end
                    end
                endcase
            end
            S_IND: begin
                mem_ra = mem_q[AW-1:0];
                unique case (op_reg) inside
                    OP_LOAD: begin
                        fin      = 1'b1;
                        mem_we   = 1'b1;
                        mem_wd   = mem_q;
                        cnt_next = cnt_p1;
                    end
                    OP_LOADI: begin
                        if (mem_q >= DEPTH_W) begin
                            fin    = 1'b1;
                            fin_st = ST_FAULT;
                        end else begin
                            state_next = S_IND2;
                        end
                    end
                    default: begin
                        if (mem_q >= DEPTH_W) begin
                            fin    = 1'b1;
                            fin_st = ST_FAULT;
                        end else begin
                            acc_next   = mem_q;
                            mem_ra     = cnt_m1[AW-1:0];
                            state_next = S_RY;
                        end
                    end
                endcase
            end
            S_IND2: begin
                fin      = 1'b1;
                mem_we   = 1'b1;
                mem_wd   = mem_q;
                cnt_next = cnt_p1;
            end
            S_EXE: begin
                alu_x  = x_reg;
                alu_y  = y_reg;
                mem_wa = cnt_m2[AW-1:0];
                mem_wd = alu_res;
                unique case (op_reg) inside
                    OP_DIV: begin
                        if (y_reg == '0) begin
                            fin    = 1'b1;
                            fin_st = ST_DIVZ;
                            fin_pc = pc_reg;
                        end else begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR,
                    OP_LT, OP_GT, OP_EQ, OP_LE, OP_GE, OP_NE: begin
                        unique case (op_reg) inside
                            OP_SUB:  alu_op = ALU_SUB;
                            OP_MUL:  alu_op = ALU_MUL;
                            OP_AND:  alu_op = ALU_LAND;
                            OP_OR:   alu_op = ALU_LOR;
                            OP_LT:   alu_op = ALU_LT;
                            OP_GT:   alu_op = ALU_GT;
                            OP_EQ:   alu_op = ALU_EQ;
                            OP_LE:   alu_op = ALU_LE;
                            OP_GE:   alu_op = ALU_GE;
                            OP_NE:   alu_op = ALU_NE;
                            default: alu_op = ALU_ADD;
                        endcase
                        fin      = 1'b1;
                        mem_we   = 1'b1;
                        cnt_next = cnt_m1;
                    end
                    OP_NEG, OP_NOT: begin
                        alu_op = ALU_SUB;
                        alu_x  = (op_reg == OP_NOT) ? WORD_BITS'(1) : '0;
                        fin    = 1'b1;
                        mem_we = 1'b1;
                        mem_wa = cnt_m1[AW-1:0];
                    end
                    OP_PRINT: begin
                        fin      = 1'b1;
                        fin_pv   = 1'b1;
                        fin_pval = y_reg;
                        cnt_next = cnt_m1;
                    end
                    OP_JMPF: begin
                        fin      = 1'b1;
                        fin_pc   = (y_reg == '0) ? tgt_reg : pc_inc;
                        cnt_next = cnt_m1;
                    end
                    OP_RET: begin
                        fin      = 1'b1;
                        fin_pc   = mem_q[PC_BITS-1:0];
                        disp_we  = 1'b1;
                        disp_wd  = y_reg;
                        cnt_next = nc_ret[CW-1:0];
                    end
                    default: begin
                        fin      = 1'b1;
                        mem_we   = 1'b1;
                        mem_wa   = acc_reg[AW-1:0];
                        mem_wd   = y_reg;
                        cnt_next = cnt_m1;
                    end
                endcase
            end
            S_DIV: begin
                mem_wa = cnt_m2[AW-1:0];
                mem_wd = div_q;
                if (div_done) begin
                    fin      = 1'b1;
                    mem_we   = 1'b1;
                    cnt_next = cnt_m1;
                end
            end
            S_WR2: begin
                fin      = 1'b1;
                fin_pc   = tgt_reg;
                mem_we   = 1'b1;
                mem_wa   = cnt_p1[AW-1:0];
                mem_wd   = b_reg;
                cnt_next = cnt_reg + CW'(2);
            end
            S_UW: begin
                alu_op   = ALU_SUB;
                alu_x    = dl_val;
                alu_y    = WORD_BITS'(2);
                acc_next = alu_res;
                mem_ra   = alu_res[AW-1:0];
                if (cur_reg == a_reg) begin
                    fin    = 1'b1;
                    fin_pc = tgt_reg;
                    commit = 1'b1;
                end else if (ucnt_reg >= UCW'(DISPLAY_LEVELS) || cur_reg >= LVL_W ||
                             alu_res >= DEPTH_W - WORD_BITS'(1)) begin
                    fin    = 1'b1;
                    fin_st = ST_FAULT;
                end else begin
                    state_next = S_UW1;
                end
            end
            S_UW1: begin
                x_next     = mem_q;
                mem_ra     = acc_reg[AW-1:0] + AW'(1);
                state_next = S_UW2;
            end
            S_UW2: begin
                sh_we      = 1'b1;
                cur_next   = x_reg;
                ucnt_next  = ucnt_reg + UCW'(1);
                state_next = S_UW;
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (fin) begin
            if (fin_st == ST_FAULT) begin
                fin_pc = pc_reg;
            end
            state_next    = S_OUT;
            pc_next       = fin_pc;
            stop_next     = stop_reg || (fin_st != ST_RUN);
            res_pc_next   = fin_pc;
            res_pv_next   = fin_pv;
            res_pval_next = fin_pval;
            res_st_next   = fin_st;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            pc_reg    <= '0;
            stop_reg  <= 1'b0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pc_reg    <= pc_next;
            stop_reg  <= stop_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        acc_reg       <= acc_next;
        cur_reg       <= cur_next;
        ucnt_reg      <= ucnt_next;
        res_pc_reg    <= res_pc_next;
        res_pv_reg    <= res_pv_next;
        res_pval_reg  <= res_pval_next;
        res_st_reg    <= res_st_next;
        if (accept) begin
            op_reg  <= s_tdata[5:0];
            a_reg   <= s_tdata[37:6];
            b_reg   <= s_tdata[69:38];
            tgt_reg <= s_tdata[79:70];
            rv_reg  <= s_tdata[111:80];
        end
    end

    // display registers and the unwinding shadow copy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DISPLAY_LEVELS; i++) begin
                disp_reg[i] <= '0;
            end
        end else if (commit) begin
            for (int i = 0; i < DISPLAY_LEVELS; i++) begin
                if (dirty_reg[i]) begin
                    disp_reg[i] <= sh_reg[i];
                end
            end
        end else if (disp_we) begin
            disp_reg[disp_wi] <= disp_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dirty_reg <= '0;
        end else if (dirty_clr) begin
            dirty_reg <= '0;
        end else if (sh_we) begin
            dirty_reg[cur_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (sh_we) begin
            sh_reg[cur_idx] <= mem_q;
        end
    end

    // stack ram, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        mem_q <= mem[mem_ra];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && out_free) begin
            m_pc_reg   <= res_pc_reg;
            m_pv_reg   <= res_pv_reg;
            m_pval_reg <= res_pval_reg;
            m_st_reg   <= res_st_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_pval_reg, m_pc_reg};
    assign m_tuser  = {m_st_reg, m_pv_reg};

endmodule

`default_nettype wire

@@ hw/rtl/pme_checker.sv @@
// ----------------------------------------------------------------------------
// pme_checker
// port level checks of the executor, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module pme_checker (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [pme_pkg::OUT_DATA_W-1:0]  m_tdata,
    input wire [pme_pkg::OUT_USER_W-1:0]  m_tuser
);
    import pme_pkg::*;

    // one instruction at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input beat taken twice in a row");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    a_print_running: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == ST_RUN)
        else $error("print beat with error status");

    a_print_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[41:10] == '0)
        else $error("print value set without print");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("activity right after reset");

endmodule

bind pascal_stack_machine_executor_unit pme_checker u_pme_checker (.*);

`default_nettype wire

@@ tb/tb_pascal_stack_machine_executor_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pascal_stack_machine_executor_unit
// self-checking bench for the stack machine executor: a queue of instruction
// beats (directed program fragments, then non-trapping random code, then one
// terminating instruction and more beats on the stopped machine) is driven
// with random gaps and backpressure; each result beat is checked against a behavioral machine model
// ----------------------------------------------------------------------------
module tb_pascal_stack_machine_executor_unit;
    import pme_pkg::*;

    typedef struct {
        opc_t  op;
        word_t a;
        word_t b;
        pc_t   tgt;
        word_t rd;
    } instr_t;

    typedef struct {
        pc_t     npc;
        logic    pv;
        word_t   pval;
        status_t st;
    } outcome_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    pascal_stack_machine_executor_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // machine model state
    word_t    stk [STACK_DEPTH];
    word_t    disp [DISPLAY_LEVELS];
    int       top;
    pc_t      pc;
    bit       halted;

    instr_t   pending_instrs [$];
    outcome_t expected_outcomes [$];
    int       n_total, n_sent, n_checked, n_errors, n_prints;

    function automatic bit in_top_range(longint t);
        return t >= -1 && t <= STACK_DEPTH - 1;
    endfunction

    // executes one instruction; commit = 0 evaluates without touching state
    function automatic void execute(input instr_t it, input bit commit, output outcome_t res);
        word_t x, y, r, ad, ad2, cur;
        word_t dl [DISPLAY_LEVELS];
        longint nt;
        int cnt;
        bit flt;
        pc_t nxt, inc;
        inc = pc + 1'b1;
        nxt = pc;
        flt = 0;
        res.pv = 0;
        res.pval = '0;
        res.st = ST_RUN;
        if (halted) begin
            res.st = ST_HALT;
        end else if (it.op >= OP_ADD && it.op <= OP_NE && it.op != OP_NEG && it.op != OP_NOT) begin
            if (top < 1) begin
                flt = 1;
            end else begin
                x = stk[top-1];
                y = stk[top];
                case (it.op)
                    OP_ADD: r = x + y;
                    OP_SUB: r = x - y;
                    OP_MUL: r = x * y;
                    OP_DIV: begin
                        if (y == 0) res.st = ST_DIVZ;
                        else if (x == 32'h8000_0000 && y == '1) r = x;
                        else r = $signed(x) / $signed(y);
                    end
                    OP_AND: r = (x != 0 && y != 0);
                    OP_OR:  r = (x != 0 || y != 0);
                    OP_LT:  r = $signed(x) < $signed(y);
                    OP_GT:  r = $signed(x) > $signed(y);
                    OP_EQ:  r = x == y;
                    OP_LE:  r = $signed(x) <= $signed(y);
                    OP_GE:  r = $signed(x) >= $signed(y);
                    default: r = x != y;
                endcase
                if (res.st == ST_DIVZ) begin
                    if (commit) halted = 1;
                end else begin
                    if (commit) begin
                        stk[top-1] = r;
                        top--;
                    end
                    nxt = inc;
                end
            end
        end else begin
            case (it.op)
                OP_INIT: begin
                    if (commit) begin
                        top = -1;
                        disp[0] = '0;
                    end
                    nxt = inc;
                end
                OP_NEG, OP_NOT: begin
                    if (top < 0) flt = 1;
                    else begin
                        if (commit) stk[top] = (it.op == OP_NEG ? 32'd0 : 32'd1) - stk[top];
                        nxt = inc;
                    end
                end
                OP_READ, OP_PUSHC: begin
                    if (top + 1 >= STACK_DEPTH) flt = 1;
                    else begin
                        if (commit) begin
                            stk[top+1] = it.op == OP_READ ? it.rd : it.a;
                            top++;
                        end
                        nxt = inc;
                    end
                end
                OP_PRINT: begin
                    if (top < 0) flt = 1;
                    else begin
                        res.pv = 1;
                        res.pval = stk[top];
                        if (commit) top--;
                        nxt = inc;
                    end
                end
                OP_ALLOC, OP_DEALLOC: begin
                    nt = it.op == OP_ALLOC ? top + longint'($signed(it.a))
                                           : top - longint'($signed(it.a));
                    if (!in_top_range(nt)) flt = 1;
                    else begin
                        if (commit) top = int'(nt);
                        nxt = inc;
                    end
                end
                OP_LOAD, OP_LOADI, OP_PUSHA: begin
                    if (it.a >= DISPLAY_LEVELS || top + 1 >= STACK_DEPTH) flt = 1;
                    else begin
                        ad = disp[it.a] + it.b;
                        r = ad;
                        if (it.op != OP_PUSHA) begin
                            if (ad >= STACK_DEPTH) flt = 1;
                            else begin
                                r = stk[ad];
                                if (it.op == OP_LOADI) begin
                                    if (r >= STACK_DEPTH) flt = 1;
                                    else r = stk[r];
                                end
                            end
                        end
                        if (!flt) begin
                            if (commit) begin
                                stk[top+1] = r;
                                top++;
                            end
                            nxt = inc;
                        end
                    end
                end
                OP_STORE, OP_STOREI: begin
                    if (it.a >= DISPLAY_LEVELS || top < 0) flt = 1;
                    else begin
                        ad = disp[it.a] + it.b;
                        if (ad >= STACK_DEPTH) flt = 1;
                        else if (it.op == OP_STOREI) begin
                            ad = stk[ad];
                            if (ad >= STACK_DEPTH) flt = 1;
                        end
                        if (!flt) begin
                            if (commit) begin
                                stk[ad] = stk[top];
                                top--;
                            end
                            nxt = inc;
                        end
                    end
                end
                OP_JUMP: nxt = it.tgt;
                OP_JMPF: begin
                    if (top < 0) flt = 1;
                    else begin
                        nxt = stk[top] == 0 ? it.tgt : inc;
                        if (commit) top--;
                    end
                end
                OP_CALL: begin
                    if (top + 2 >= STACK_DEPTH) flt = 1;
                    else begin
                        if (commit) begin
                            stk[top+1] = {21'd0, {1'b0, pc} + 11'd1};
                            stk[top+2] = it.b;
                            top += 2;
                        end
                        nxt = it.tgt;
                    end
                end
                OP_ENTER: begin
                    if (it.a >= DISPLAY_LEVELS || top + 1 >= STACK_DEPTH) flt = 1;
                    else begin
                        if (commit) begin
                            stk[top+1] = disp[it.a];
                            disp[it.a] = top + 2;
                            top++;
                        end
                        nxt = inc;
                    end
                end
                OP_RET: begin
                    nt = top - longint'($signed(it.b)) - 3;
                    if (it.a >= DISPLAY_LEVELS || top < 2 || !in_top_range(nt)) flt = 1;
                    else begin
                        nxt = stk[top-2][PC_BITS-1:0];
                        if (commit) begin
                            disp[it.a] = stk[top];
                            top = int'(nt);
                        end
                    end
                end
                OP_LABEL: begin
                    if (it.a >= DISPLAY_LEVELS) flt = 1;
                    else begin
                        r = disp[it.a] + it.b - 32'd1;
                        nt = longint'($signed(r));
                        if (!in_top_range(nt)) flt = 1;
                        else begin
                            if (commit) top = int'(nt);
                            nxt = inc;
                        end
                    end
                end
                OP_GOTO: begin
                    dl = disp;
                    cur = it.b;
                    cnt = 0;
                    while (cur != it.a && !flt) begin
                        if (cnt >= DISPLAY_LEVELS || cur >= DISPLAY_LEVELS) flt = 1;
                        else begin
                            ad = dl[cur] - 32'd2;
                            ad2 = dl[cur] - 32'd1;
                            if (ad >= STACK_DEPTH || ad2 >= STACK_DEPTH) flt = 1;
                            else begin
                                r = stk[ad];
                                dl[cur] = stk[ad2];
                                cur = r;
                                cnt++;
                            end
                        end
                    end
                    if (!flt) begin
                        if (commit) disp = dl;
                        nxt = it.tgt;
                    end
                end
                OP_HALT: begin
                    res.st = ST_HALT;
                    if (commit) halted = 1;
                end
                default: nxt = inc;
            endcase
            if (flt) begin
                res.st = ST_FAULT;
                nxt = pc;
                if (commit) halted = 1;
            end
        end
        if (flt && it.op >= OP_ADD && it.op <= OP_NE) begin
            res.st = ST_FAULT;
            if (commit) halted = 1;
        end
        res.npc = nxt;
        if (commit) pc = nxt;
    endfunction

    // queue an instruction; unless forced, only one that keeps the machine running
    function automatic bit issue(input instr_t it, input bit force_it);
        outcome_t res;
        execute(it, 0, res);
        if (!force_it && res.st != ST_RUN) return 0;
        execute(it, 1, res);
        pending_instrs.push_back(it);
        expected_outcomes.push_back(res);
        return 1;
    endfunction

    function automatic instr_t mk(opc_t op, word_t a, word_t b, pc_t tgt = '0, word_t rd = '0);
        instr_t it;
        it.op = op; it.a = a; it.b = b; it.tgt = tgt; it.rd = rd;
        return it;
    endfunction

    function automatic word_t pick_word();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(20);
            2: return word_t'($signed($urandom_range(6)) - 3);
            default: return $urandom_range(top + 4);
        endcase
    endfunction

    function automatic instr_t random_instr();
        instr_t it;
        opc_t common_ops [12] = '{OP_PUSHC, OP_READ, OP_PUSHC, OP_LOAD, OP_STORE, OP_PUSHA,
                                 OP_ADD, OP_PRINT, OP_JMPF, OP_ALLOC, OP_LOADI, OP_STOREI};
        if ($urandom_range(99) < 35) it.op = common_ops[$urandom_range(11)];
        else it.op = opc_t'($urandom_range(63));
        it.a = pick_word();
        it.b = pick_word();
        it.tgt = pc_t'($urandom);
        it.rd = $urandom;
        if (it.op inside {OP_LOAD, OP_STORE, OP_LOADI, OP_STOREI, OP_PUSHA, OP_ENTER,
                          OP_RET, OP_LABEL} && $urandom_range(3) != 0)
            it.a = $urandom_range(2);
        return it;
    endfunction

    initial begin
        instr_t it;
        int tries;
        bit ok;
        stk = '{default: '0};
        disp = '{default: '0};
        top = -1;
        pc = '0;
        halted = 0;
        // directed: arithmetic extremes and every opcode but halt
        ok = issue(mk(OP_INIT, 0, 0), 0);
        ok = issue(mk(OP_PUSHC, 32'h7fff_ffff, '1), 0);
        ok = issue(mk(OP_PUSHC, 32'h8000_0000, 0), 0);
        ok = issue(mk(OP_ADD, 0, 0), 0);
        ok = issue(mk(OP_PUSHC, 32'h8000_0000, 0), 0);
        ok = issue(mk(OP_READ, 0, 0, 0, '1), 0);
        ok = issue(mk(OP_DIV, 0, 0), 0);
        ok = issue(mk(OP_PUSHC, -7, 0), 0);
        ok = issue(mk(OP_DIV, 0, 0), 0);
        ok = issue(mk(OP_MUL, 0, 0), 0);
        ok = issue(mk(OP_NEG, 0, 0), 0);
        ok = issue(mk(OP_NOT, 0, 0), 0);
        ok = issue(mk(OP_PRINT, 0, 0), 0);
        for (int op = OP_ADD; op <= OP_NE; op++) begin
            if (op == OP_NEG || op == OP_NOT) continue;
            ok = issue(mk(OP_READ, 0, 0, 0, $urandom), 0);
            ok = issue(mk(OP_PUSHC, $urandom_range(1) ? $urandom : 0, 0), 0);
            ok = issue(mk(opc_t'(op), 0, 0), 0);
        end
        ok = issue(mk(OP_NOP, '1, '1, '1, '1), 0);
        ok = issue(mk(OP_ALLOC, 3, 0), 0);
        ok = issue(mk(OP_STORE, 0, 1), 0);
        ok = issue(mk(OP_LOAD, 0, 0), 0);
        ok = issue(mk(OP_PUSHA, 0, 2), 0);
        ok = issue(mk(OP_STOREI, 0, 0), 0);
        ok = issue(mk(OP_LOADI, 0, 0), 0);
        ok = issue(mk(OP_DEALLOC, 1, 0), 0);
        ok = issue(mk(OP_CALL, 0, 0, 10'd100), 0);
        ok = issue(mk(OP_ENTER, 1, 0), 0);
        ok = issue(mk(OP_ALLOC, 2, 0), 0);
        ok = issue(mk(OP_LABEL, 1, 2), 0);
        ok = issue(mk(OP_GOTO, 0, 1, 10'd200), 0);
        ok = issue(mk(OP_DEALLOC, 2, 0), 0);
        ok = issue(mk(OP_RET, 1, 0), 0);
        ok = issue(mk(OP_JUMP, 0, 0, 10'd1023), 0);
        ok = issue(mk(OP_PUSHC, 0, 0), 0);
        ok = issue(mk(OP_JMPF, 0, 0, 10'd5), 0);
        // random code that keeps running
        for (int i = 0; i < 900; i++) begin
            ok = 0;
            for (tries = 0; tries < 300 && !ok; tries++) ok = issue(random_instr(), 0);
            if (!ok) ok = issue(mk(OP_NOP, $urandom, $urandom, pc_t'($urandom), $urandom), 0);
        end
        // one terminating instruction, then a few beats on the stopped machine
        case ($urandom_range(2))
            0: ok = issue(mk(OP_HALT, 0, 0), 1);
            1: ok = issue(mk(OP_LOAD, DISPLAY_LEVELS, 0), 1);
            default: begin
                ok = issue(mk(OP_PUSHC, 1, 0), 1);
                ok = issue(mk(OP_PUSHC, 0, 0), 1);
                ok = issue(mk(OP_DIV, 0, 0), 1);
            end
        endcase
        for (int i = 0; i < 6; i++) begin
            it = random_instr();
            ok = issue(it, 1);
        end
        ok = issue(mk(OP_HALT, 0, 0), 1);
        n_total = pending_instrs.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_instrs.size() != 0 || s_tvalid || expected_outcomes.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("%0d instructions issued, %0d results checked, %0d prints",
                 n_sent, n_checked, n_prints);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int tx_idle_pct();
        if (n_sent < n_total / 3) return 27;
        if (n_sent < 2 * n_total / 3) return 47;
        return 0;
    endfunction

    function automatic int rx_idle_pct();
        if (n_sent < n_total / 3) return 47;
        if (n_sent < 2 * n_total / 3) return 27;
        return 0;
    endfunction

    // driver
    always @(posedge aclk) begin
        instr_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) n_sent++;
            if (pending_instrs.size() != 0 && $urandom_range(99) >= tx_idle_pct()) begin
                it = pending_instrs.pop_front();
                s_tdata <= {it.rd, it.tgt, it.b, it.a, it.op};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        outcome_t e;
        m_tready <= aresetn && $urandom_range(99) >= rx_idle_pct();
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_outcomes.size() == 0) begin
                $display("%t unexpected result beat: tdata %h tuser %h", $time, m_tdata, m_tuser);
                n_errors++;
            end else begin
                e = expected_outcomes.pop_front();
                n_checked++;
                if (e.pv) n_prints++;
                if (m_tdata[9:0] !== e.npc) begin
                    $display("%t next_pc expected %h actual %h", $time, e.npc, m_tdata[9:0]);
                    n_errors++;
                end
                if (m_tdata[41:10] !== e.pval) begin
                    $display("%t print_value expected %h actual %h", $time, e.pval,
                             m_tdata[41:10]);
                    n_errors++;
                end
                if (m_tuser[0] !== e.pv) begin
                    $display("%t print_valid expected %b actual %b", $time, e.pv, m_tuser[0]);
                    n_errors++;
                end
                if (m_tuser[2:1] !== e.st) begin
                    $display("%t status expected %0d actual %0d", $time, e.st, m_tuser[2:1]);
                    n_errors++;
                end
            end
        end
    end

endmodule
